// ----- rtl/core/washer_cycle_sequencer_macros.svh -----
// Assertion macros for the washer cycle sequencer RTL.
// No dependencies; included by modules that carry concurrent assertions.
`ifndef WASHER_CYCLE_SEQUENCER_MACROS_SVH
`define WASHER_CYCLE_SEQUENCER_MACROS_SVH

// same-cycle implication
`define WCS_ASSERT_NOW(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// next-cycle implication
`define WCS_ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

// ----- rtl/core/wcs_pkg.sv -----
// Shared types and constants for the washer cycle sequencer.
// No dependencies; used by the top level.
`default_nettype none

package wcs_pkg;

  localparam int TIMER_BITS_DEF = 16;
  localparam int TIME_W         = 16;
  localparam int REP_W          = 4;
  localparam int EL_W           = 10;
  localparam int CFG_IDX_W      = 3;
  localparam int DRV_W          = 5;

  localparam logic [TIME_W-1:0] FILL_TIME_DEF  = 16'd3000;
  localparam logic [TIME_W-1:0] DET_TIME_DEF   = 16'd2000;
  localparam logic [TIME_W-1:0] WASH_TIME_DEF  = 16'd5000;
  localparam logic [TIME_W-1:0] DRAIN_TIME_DEF = 16'd5000;
  localparam logic [REP_W-1:0]  REPEATS_DEF    = 4'd5;

  localparam int DRV_WATER = 0;
  localparam int DRV_DET   = 1;
  localparam int DRV_DRAIN = 2;
  localparam int DRV_CW    = 3;
  localparam int DRV_CCW   = 4;

  typedef enum logic [2:0] {
    PH_WAIT  = 3'd0,
    PH_FILL  = 3'd1,
    PH_DET   = 3'd2,
    PH_RIGHT = 3'd3,
    PH_LEFT  = 3'd4,
    PH_DRAIN = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    MODE_COMPLETE = 2'd0,
    MODE_RINSE    = 2'd1,
    MODE_DRY      = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILL    = 3'd0,
    CFG_DET     = 3'd1,
    CFG_WASH    = 3'd2,
    CFG_DRAIN   = 3'd3,
    CFG_REPEATS = 3'd4
  } cfg_idx_t;

endpackage

`default_nettype wire

// ----- rtl/core/wcs_if.sv -----
// Channel interfaces of the washer cycle sequencer: tick input, drive result
// and register write. No dependencies.
`default_nettype none

interface wcs_in_if;
  logic       valid;
  logic       ready;
  logic       stop_pressed;
  logic       start_pressed;
  logic       sel_complete;
  logic       sel_rinse;
  logic       sel_dry;
  logic [9:0] elapsed_ms;

  modport source (output valid, stop_pressed, start_pressed, sel_complete, sel_rinse,
                  sel_dry, elapsed_ms, input ready);
  modport sink (input valid, stop_pressed, start_pressed, sel_complete, sel_rinse,
                sel_dry, elapsed_ms, output ready);
endinterface

interface wcs_out_if;
  logic       valid;
  logic       ready;
  logic       water_valve;
  logic       detergent_valve;
  logic       drain_valve;
  logic       motor_cw;
  logic       motor_ccw;
  logic [2:0] phase;
  logic [1:0] active_mode;
  logic       cycle_done;

  modport source (output valid, water_valve, detergent_valve, drain_valve, motor_cw,
                  motor_ccw, phase, active_mode, cycle_done, input ready);
  modport sink (input valid, water_valve, detergent_valve, drain_valve, motor_cw,
                motor_ccw, phase, active_mode, cycle_done, output ready);
endinterface

interface wcs_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/washer_cycle_sequencer.sv -----
// Washer cycle sequencer top level: tick register, phase/mode state and result register.
// Depends on wcs_pkg, wcs_if.sv and washer_cycle_sequencer_macros.svh.
//
//   channel | dir | transaction
//   in_s    | in  | one tick: buttons, mode switches, elapsed_ms
//   out_s   | out | drives, phase, active_mode, cycle_done for that tick
//   cfg_s   | in  | register index and 16-bit write data
//
// Sustained rate is one transaction per cycle while out_s is ready; a tick passes through
// the tick register, then the phase/timer update that loads the result register.
// Synchronous reset clears state and reloads the register defaults.
// A stalled out_s holds its result; one more tick waits in the tick register.
// cfg_s is always ready.
`default_nettype none

module washer_cycle_sequencer #(
  parameter int TIMER_BITS = wcs_pkg::TIMER_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  wcs_in_if.sink     in_s,
  wcs_out_if.source  out_s,
  wcs_cfg_if.sink    cfg_s
);
  import wcs_pkg::*;
  `include "washer_cycle_sequencer_macros.svh"

  localparam int EXT_W = (TIMER_BITS > EL_W) ? TIMER_BITS : EL_W;
  localparam int SUM_W = EXT_W + 1;
  localparam int CMP_W = (TIMER_BITS > TIME_W) ? TIMER_BITS : TIME_W;
  localparam logic [SUM_W-1:0] TMAX = SUM_W'((64'd1 << TIMER_BITS) - 64'd1);

  logic [TIME_W-1:0] fill_time_r, det_time_r, wash_time_r, drain_time_r;
  logic [REP_W-1:0]  repeats_r;

  logic            in_vld_r;
  logic            in_stop_r, in_start_r, in_comp_r, in_rinse_r, in_dry_r;
  logic [EL_W-1:0] in_el_r;

  phase_t                phase_r, phase_nxt;
  mode_t                 mode_r, mode_nxt;
  logic [REP_W-1:0]      pair_r, pair_nxt;
  logic [TIMER_BITS-1:0] timer_r, timer_nxt;
  logic [DRV_W-1:0]      drive_r, drive_nxt;
  logic                  done_nxt;

  logic                  out_vld_r, done_r;
  logic [DRV_W-1:0]      out_drive_r;
  logic [2:0]            out_phase_r;
  logic [1:0]            out_mode_r;

  logic                  adv, in_take;
  logic [SUM_W-1:0]      timer_sum;
  logic [TIMER_BITS-1:0] timer_sat;
  logic                  to_fill, to_det, to_wash, to_drain;
  logic [DRV_W-1:0]      drv_right, drv_left, drv_det, drv_drain, drv_fill;

  assign adv     = in_vld_r && (!out_vld_r || out_s.ready);
  assign in_take = in_s.valid && in_s.ready;
  assign in_s.ready  = !in_vld_r || adv;
  assign cfg_s.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_time_r  <= FILL_TIME_DEF;
      det_time_r   <= DET_TIME_DEF;
      wash_time_r  <= WASH_TIME_DEF;
      drain_time_r <= DRAIN_TIME_DEF;
      repeats_r    <= REPEATS_DEF;
    end else if (cfg_s.valid) begin
      unique case (cfg_s.index)
        CFG_FILL:    fill_time_r  <= cfg_s.wdata;
        CFG_DET:     det_time_r   <= cfg_s.wdata;
        CFG_WASH:    wash_time_r  <= cfg_s.wdata;
        CFG_DRAIN:   drain_time_r <= cfg_s.wdata;
        CFG_REPEATS: repeats_r    <= cfg_s.wdata[REP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_stop_r  <= in_s.stop_pressed;
      in_start_r <= in_s.start_pressed;
      in_comp_r  <= in_s.sel_complete;
      in_rinse_r <= in_s.sel_rinse;
      in_dry_r   <= in_s.sel_dry;
      in_el_r    <= in_s.elapsed_ms;
    end
  end

  assign timer_sum = SUM_W'(timer_r) + SUM_W'(in_el_r);
  assign timer_sat = (timer_sum > TMAX) ? {TIMER_BITS{1'b1}} : timer_sum[TIMER_BITS-1:0];
  assign to_fill   = CMP_W'(timer_sat) >= CMP_W'(fill_time_r);
  assign to_det    = CMP_W'(timer_sat) >= CMP_W'(det_time_r);
  assign to_wash   = CMP_W'(timer_sat) >= CMP_W'(wash_time_r);
  assign to_drain  = CMP_W'(timer_sat) >= CMP_W'(drain_time_r);

  always_comb begin
    drv_right = drive_r;
    drv_right[DRV_DET]   = 1'b0;
    drv_right[DRV_WATER] = 1'b0;
    drv_right[DRV_CCW]   = 1'b0;
    drv_right[DRV_CW]    = 1'b1;
    drv_left = drive_r;
    drv_left[DRV_CW]     = 1'b0;
    drv_left[DRV_CCW]    = 1'b1;
    drv_det = drive_r;
    drv_det[DRV_WATER]   = 1'b0;
    drv_det[DRV_DET]     = 1'b1;
    drv_drain = drive_r;
    drv_drain[DRV_CW]    = 1'b0;
    drv_drain[DRV_CCW]   = 1'b0;
    drv_drain[DRV_DRAIN] = 1'b1;
    drv_fill = drive_r;
    drv_fill[DRV_WATER]  = 1'b1;
  end

  always_comb begin
    phase_nxt = phase_r;
    mode_nxt  = mode_r;
    pair_nxt  = pair_r;
    timer_nxt = timer_sat;
    drive_nxt = drive_r;
    done_nxt  = 1'b0;
    if (in_stop_r) begin
      phase_nxt = PH_WAIT;
      drive_nxt = '0;
    end else begin
      if (phase_r == PH_WAIT) begin
        priority if (in_comp_r) begin
          mode_nxt = MODE_COMPLETE;
        end else if (in_rinse_r) begin
          mode_nxt = MODE_RINSE;
        end else if (in_dry_r) begin
          mode_nxt = MODE_DRY;
        end else begin
          mode_nxt = mode_r;
        end
      end
      unique case (phase_r)
        PH_WAIT: begin
          if (in_start_r) begin
            timer_nxt = '0;
            if (mode_nxt == MODE_DRY) begin
              pair_nxt  = '0;
              phase_nxt = PH_RIGHT;
              drive_nxt = drv_right;
            end else begin
              phase_nxt = PH_FILL;
              drive_nxt = drv_fill;
            end
          end
        end
        PH_FILL: begin
          if (to_fill && mode_r == MODE_COMPLETE) begin
            timer_nxt = '0;
            phase_nxt = PH_DET;
            drive_nxt = drv_det;
          end else if (to_fill && mode_r == MODE_RINSE) begin
            timer_nxt = '0;
            pair_nxt  = '0;
            phase_nxt = PH_RIGHT;
            drive_nxt = drv_right;
          end
        end
        PH_DET: begin
          if (to_det && mode_r == MODE_COMPLETE) begin
            timer_nxt = '0;
            pair_nxt  = '0;
            phase_nxt = PH_RIGHT;
            drive_nxt = drv_right;
          end
        end
        PH_RIGHT: begin
          if (to_wash) begin
            timer_nxt = '0;
            phase_nxt = PH_LEFT;
            drive_nxt = drv_left;
          end
        end
        PH_LEFT: begin
          if (to_wash) begin
            timer_nxt = '0;
            if (pair_r < repeats_r) begin
              pair_nxt  = pair_r + REP_W'(1);
              phase_nxt = PH_RIGHT;
              drive_nxt = drv_right;
            end else begin
              pair_nxt  = '0;
              phase_nxt = PH_DRAIN;
              drive_nxt = drv_drain;
            end
          end
        end
        PH_DRAIN: begin
          if (to_drain) begin
            phase_nxt = PH_WAIT;
            drive_nxt = '0;
            done_nxt  = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_WAIT;
      mode_r    <= MODE_COMPLETE;
      pair_r    <= '0;
      timer_r   <= '0;
      drive_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (adv) begin
        phase_r   <= phase_nxt;
        mode_r    <= mode_nxt;
        pair_r    <= pair_nxt;
        timer_r   <= timer_nxt;
        drive_r   <= drive_nxt;
        out_vld_r <= 1'b1;
      end else if (out_s.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_drive_r <= drive_nxt;
      out_phase_r <= phase_nxt;
      out_mode_r  <= mode_nxt;
      done_r      <= done_nxt;
    end
  end

  assign out_s.valid           = out_vld_r;
  assign out_s.water_valve     = out_drive_r[DRV_WATER];
  assign out_s.detergent_valve = out_drive_r[DRV_DET];
  assign out_s.drain_valve     = out_drive_r[DRV_DRAIN];
  assign out_s.motor_cw        = out_drive_r[DRV_CW];
  assign out_s.motor_ccw       = out_drive_r[DRV_CCW];
  assign out_s.phase           = out_phase_r;
  assign out_s.active_mode     = out_mode_r;
  assign out_s.cycle_done      = done_r;

  `WCS_ASSERT_NOW(a_one_drive, clk, rst_n, 1'b1, $onehot0(drive_r), "more than one drive active")
  `WCS_ASSERT_NOW(a_wait_idle, clk, rst_n, phase_r == PH_WAIT, drive_r == '0, "drive on in wait")
  `WCS_ASSERT_NOW(a_done_wait, clk, rst_n, out_vld_r && done_r,
                  out_phase_r == 3'(PH_WAIT) && out_drive_r == '0, "done without return to wait")
  `WCS_ASSERT_NEXT(a_adv_out, clk, rst_n, adv, out_vld_r, "result lost after advance")
  `WCS_ASSERT_NEXT(a_hold_tick, clk, rst_n, in_vld_r && !adv, in_vld_r, "pending tick dropped")

endmodule

`default_nettype wire
